@@ design/mersenne_twister_generator_macros.svh @@
// Assertion helpers shared by the generator RTL.
`ifndef MERSENNE_TWISTER_GENERATOR_MACROS_SVH
`define MERSENNE_TWISTER_GENERATOR_MACROS_SVH

// Same-cycle implication, checked out of reset
`define MTG_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define MTG_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ design/mtg_pkg.sv @@
package mtg_pkg;

    typedef logic [31:0] word_t;
    typedef logic [9:0]  pos_t;

    // Store geometry
    localparam pos_t STATE_WORDS   = 10'd624;
    localparam pos_t MIDDLE_OFFSET = 10'd397;
    localparam pos_t MID_WRAP      = STATE_WORDS - MIDDLE_OFFSET;
    localparam pos_t LAST_WORD     = STATE_WORDS - 10'd1;
    localparam pos_t UNSEEDED      = STATE_WORDS + 10'd1;

    // Recurrence constants
    localparam word_t TWIST_MATRIX = 32'h9908_b0df;
    localparam word_t INIT_MULT    = 32'd1812433253;
    localparam word_t DEFAULT_SEED = 32'd5489;
    localparam word_t TEMPER_B     = 32'h9d2c_5680;
    localparam word_t TEMPER_C     = 32'hefc6_0000;

    // Action codes
    localparam logic [1:0] ACT_GEN    = 2'd0;
    localparam logic [1:0] ACT_RESEED = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;
    localparam logic [1:0] ACT_WRITE  = 2'd3;

    // One step of the twist: new word k from words k, k+1 and k+397 (indices modulo 624)
    function automatic word_t twist(input word_t cur, input word_t nxt, input word_t mid);
        word_t y;
        word_t v;
        y = {cur[31], nxt[30:0]};
        v = mid ^ (y >> 1);
        if (y[0])
        begin
            v = v ^ TWIST_MATRIX;
        end
        return v;
    endfunction

    // Output tempering
    function automatic word_t temper(input word_t w);
        word_t y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

@@ design/mersenne_twister_generator.sv @@
// MT19937 generator with a 624 x 32 state store in one synchronous RAM (one read, one
// write port, registered read). Raise start while busy is low to issue a command;
// exactly one beat comes back on result_word, marked by done for one cycle, and it cannot
// be stalled. A generate from a ready store reads the word at the position and tempers it
// in ST_GEN_OUT. Every 624th generate first regenerates the store; each word needs two
// reads and a write through the single read port, and the output word is fetched
// again after the refill. Reseed, and the first generate after reset (which seeds with
// 5489), walk the store one word at a time through the registered seed multiplier
// (ST_SEED_MUL, then ST_SEED_WR). Read and write of index 624 act on the position
// register; reads of store words return through the registered read, writes answer from idle.
`include "mersenne_twister_generator_macros.svh"

module mersenne_twister_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [9:0]  word_index,
    input  logic [31:0] data_value,
    output logic        done,
    output logic [31:0] result_word
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SEED_W0  = 4'd1;
    localparam logic [3:0] ST_SEED_MUL = 4'd2;
    localparam logic [3:0] ST_SEED_WR  = 4'd3;
    localparam logic [3:0] ST_RG_PRIME = 4'd4;
    localparam logic [3:0] ST_RG_NXT   = 4'd5;
    localparam logic [3:0] ST_RG_MID   = 4'd6;
    localparam logic [3:0] ST_RG_WR    = 4'd7;
    localparam logic [3:0] ST_GEN_RD   = 4'd8;
    localparam logic [3:0] ST_GEN_OUT  = 4'd9;
    localparam logic [3:0] ST_RD_OUT   = 4'd10;

    logic [3:0]     state_reg, state_next;
    mtg_pkg::pos_t  position_reg, position_next;
    mtg_pkg::pos_t  cnt_reg, cnt_next;
    logic           gen_pend_reg, gen_pend_next;
    logic           done_reg, done_next;
    mtg_pkg::word_t result_reg, result_next;
    mtg_pkg::word_t seed_reg, seed_next;
    mtg_pkg::word_t prev_reg, prev_next;
    mtg_pkg::word_t prod_reg, prod_next;
    mtg_pkg::word_t cur_reg, cur_next;
    mtg_pkg::word_t nxt_reg, nxt_next;
    mtg_pkg::word_t rd_data_reg;

    logic           rd_en;
    mtg_pkg::pos_t  rd_addr;
    logic           wr_en;
    mtg_pkg::pos_t  wr_addr;
    mtg_pkg::word_t wr_data;

    mtg_pkg::pos_t  nxt_idx;
    mtg_pkg::pos_t  mid_idx;
    mtg_pkg::word_t seed_word;

    mtg_pkg::word_t store_mem [0:mtg_pkg::STATE_WORDS-1];

    // State store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // Twist neighbors of word k
    assign nxt_idx = (cnt_reg == mtg_pkg::LAST_WORD) ? '0 : cnt_reg + 10'd1;
    assign mid_idx = (cnt_reg >= mtg_pkg::MID_WRAP) ? cnt_reg - mtg_pkg::MID_WRAP
                                                     : cnt_reg + mtg_pkg::MIDDLE_OFFSET;

    // Seed recurrence: registered product plus index
    assign seed_word = prod_reg + mtg_pkg::word_t'(cnt_reg);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        position_next = position_reg;
        cnt_next      = cnt_reg;
        gen_pend_next = gen_pend_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        seed_next     = seed_reg;
        prev_next     = prev_reg;
        prod_next     = prod_reg;
        cur_next      = cur_reg;
        nxt_next      = nxt_reg;
        rd_en         = 1'b0;
        rd_addr       = word_index;
        wr_en         = 1'b0;
        wr_addr       = cnt_reg;
        wr_data       = data_value;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (action)
                        mtg_pkg::ACT_GEN:
                        begin
                            if (position_reg == mtg_pkg::UNSEEDED)
                            begin
                                seed_next     = mtg_pkg::DEFAULT_SEED;
                                gen_pend_next = 1'b1;
                                state_next    = ST_SEED_W0;
                            end
                            else if (position_reg >= mtg_pkg::STATE_WORDS)
                            begin
                                state_next = ST_RG_PRIME;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = position_reg;
                                state_next = ST_GEN_OUT;
                            end
                        end
                        mtg_pkg::ACT_RESEED:
                        begin
                            seed_next     = (data_value == '1) ? mtg_pkg::DEFAULT_SEED
                                                               : data_value;
                            gen_pend_next = 1'b0;
                            state_next    = ST_SEED_W0;
                        end
                        mtg_pkg::ACT_READ:
                        begin
                            if (word_index < mtg_pkg::STATE_WORDS)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = word_index;
                                state_next = ST_RD_OUT;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                result_next = (word_index == mtg_pkg::STATE_WORDS)
                                              ? mtg_pkg::word_t'(position_reg) : '0;
                            end
                        end
                        default:
                        begin
                            if (word_index < mtg_pkg::STATE_WORDS)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = word_index;
                                wr_data = data_value;
                            end
                            else if (word_index == mtg_pkg::STATE_WORDS)
                            begin
                                position_next = data_value[9:0];
                            end
                            done_next   = 1'b1;
                            result_next = '0;
                        end
                    endcase
                end
            end

            // Seeding: word 0 is the seed itself
            ST_SEED_W0:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = seed_reg;
                prev_next  = seed_reg;
                cnt_next   = 10'd1;
                state_next = ST_SEED_MUL;
            end

            ST_SEED_MUL:
            begin
                prod_next  = mtg_pkg::word_t'(mtg_pkg::INIT_MULT * (prev_reg ^ (prev_reg >> 30)));
                state_next = ST_SEED_WR;
            end

            ST_SEED_WR:
            begin
                wr_en     = 1'b1;
                wr_addr   = cnt_reg;
                wr_data   = seed_word;
                prev_next = seed_word;
                if (cnt_reg == mtg_pkg::LAST_WORD)
                begin
                    position_next = mtg_pkg::STATE_WORDS;
                    if (gen_pend_reg)
                    begin
                        state_next = ST_RG_PRIME;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                        state_next  = ST_IDLE;
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg + 10'd1;
                    state_next = ST_SEED_MUL;
                end
            end

            // Regeneration: fetch old word 0 once, then per word read k+1, read k+397, write k
            ST_RG_PRIME:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                cnt_next   = '0;
                state_next = ST_RG_NXT;
            end

            ST_RG_NXT:
            begin
                rd_en   = 1'b1;
                rd_addr = nxt_idx;
                if (cnt_reg == '0)
                begin
                    cur_next = rd_data_reg;
                end
                state_next = ST_RG_MID;
            end

            ST_RG_MID:
            begin
                rd_en      = 1'b1;
                rd_addr    = mid_idx;
                nxt_next   = rd_data_reg;
                state_next = ST_RG_WR;
            end

            ST_RG_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = cnt_reg;
                wr_data  = mtg_pkg::twist(cur_reg, nxt_reg, rd_data_reg);
                cur_next = nxt_reg;
                if (cnt_reg == mtg_pkg::LAST_WORD)
                begin
                    position_next = '0;
                    state_next    = ST_GEN_RD;
                end
                else
                begin
                    cnt_next   = cnt_reg + 10'd1;
                    state_next = ST_RG_NXT;
                end
            end

            ST_GEN_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = position_reg;
                state_next = ST_GEN_OUT;
            end

            ST_GEN_OUT:
            begin
                done_next     = 1'b1;
                result_next   = mtg_pkg::temper(rd_data_reg);
                position_next = position_reg + 10'd1;
                state_next    = ST_IDLE;
            end

            ST_RD_OUT:
            begin
                done_next   = 1'b1;
                result_next = rd_data_reg;
                state_next  = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            position_reg <= mtg_pkg::UNSEEDED;
            cnt_reg      <= '0;
            gen_pend_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            position_reg <= position_next;
            cnt_reg      <= cnt_next;
            gen_pend_reg <= gen_pend_next;
            done_reg     <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        seed_reg   <= seed_next;
        prev_reg   <= prev_next;
        prod_reg   <= prod_next;
        cur_reg    <= cur_next;
        nxt_reg    <= nxt_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign result_word = result_reg;

    // Checks
    `MTG_ASSERT_NOW(a_wr_in_range, wr_en, wr_addr < mtg_pkg::STATE_WORDS, "store write out of range")
    `MTG_ASSERT_NOW(a_rd_in_range, rd_en, rd_addr < mtg_pkg::STATE_WORDS, "store read out of range")
    `MTG_ASSERT_NEXT(a_write_done, start && !busy && action == mtg_pkg::ACT_WRITE, done && result_word == '0, "write beat missing")
    `MTG_ASSERT_NEXT(a_regen_pos, state_reg == ST_RG_WR && cnt_reg == mtg_pkg::LAST_WORD, position_reg == '0 && state_reg == ST_GEN_RD, "regeneration did not rewind position")

endmodule

@@ tb/sv/mersenne_twister_generator_tb.sv @@
module mersenne_twister_generator_tb;

    localparam int              NWORDS      = int'(mtg_pkg::STATE_WORDS);
    localparam int              MID_STEP    = int'(mtg_pkg::MIDDLE_OFFSET);
    localparam int unsigned     ITEM_COUNT  = 400;
    localparam int unsigned     CYCLE_LIMIT = 10_000_000;
    localparam mtg_pkg::word_t  ALL_ONES    = 32'hFFFF_FFFF;

    // Scoreboard: its own MT19937 state, expected result words in issue order
    class mt_scoreboard;
        mtg_pkg::word_t store_words [NWORDS];
        bit             written [NWORDS];
        int             written_count;
        mtg_pkg::pos_t  pos_reg;
        mtg_pkg::word_t pending_words [$];
        int             fail_count;

        function new();
            pos_reg       = mtg_pkg::UNSEEDED;
            written_count = 0;
            fail_count    = 0;
            foreach (written[i])
            begin
                written[i]     = 1'b0;
                store_words[i] = '0;
            end
        endfunction

        // Init recurrence from a seed; position lands at the end of the store
        function void fill_from_seed(mtg_pkg::word_t seed);
            store_words[0] = seed;
            for (int i = 1; i < NWORDS; i++)
            begin
                store_words[i] = mtg_pkg::INIT_MULT
                                 * (store_words[i-1] ^ (store_words[i-1] >> 30))
                                 + mtg_pkg::word_t'(i);
            end
            foreach (written[i])
            begin
                written[i] = 1'b1;
            end
            written_count = NWORDS;
            pos_reg       = mtg_pkg::STATE_WORDS;
        endfunction

        // In-place refill, lowest word first (later words see updated ones)
        function void twist_all();
            mtg_pkg::word_t y;
            mtg_pkg::word_t v;
            for (int k = 0; k < NWORDS; k++)
            begin
                y = {store_words[k][31], store_words[(k + 1) % NWORDS][30:0]};
                v = store_words[(k + MID_STEP) % NWORDS] ^ (y >> 1);
                if (y[0])
                begin
                    v = v ^ mtg_pkg::TWIST_MATRIX;
                end
                store_words[k] = v;
            end
            pos_reg = '0;
        endfunction

        // Next tempered output word
        function mtg_pkg::word_t draw_word();
            mtg_pkg::word_t w;
            if (pos_reg >= mtg_pkg::STATE_WORDS)
            begin
                if (pos_reg == mtg_pkg::UNSEEDED)
                begin
                    fill_from_seed(mtg_pkg::DEFAULT_SEED);
                end
                twist_all();
            end
            w       = store_words[pos_reg];
            pos_reg = pos_reg + 10'd1;
            w = w ^ (w >> 11);
            w = w ^ ((w << 7) & mtg_pkg::TEMPER_B);
            w = w ^ ((w << 15) & mtg_pkg::TEMPER_C);
            w = w ^ (w >> 18);
            return w;
        endfunction

        // False when the command would touch a store word never written
        function bit may_issue(logic [1:0] act, mtg_pkg::pos_t idx);
            if (act == mtg_pkg::ACT_READ && idx < mtg_pkg::STATE_WORDS)
            begin
                return written[idx];
            end
            if (act == mtg_pkg::ACT_GEN && pos_reg != mtg_pkg::UNSEEDED)
            begin
                return (pos_reg < mtg_pkg::STATE_WORDS) ? written[pos_reg]
                                                        : (written_count == NWORDS);
            end
            return 1'b1;
        endfunction

        function void note_command(logic [1:0] act, mtg_pkg::pos_t idx, mtg_pkg::word_t val);
            mtg_pkg::word_t expected;
            expected = '0;
            case (act)
                mtg_pkg::ACT_GEN:
                begin
                    expected = draw_word();
                end
                mtg_pkg::ACT_RESEED:
                begin
                    fill_from_seed((val == ALL_ONES) ? mtg_pkg::DEFAULT_SEED : val);
                end
                mtg_pkg::ACT_READ:
                begin
                    if (idx < mtg_pkg::STATE_WORDS)
                    begin
                        expected = store_words[idx];
                    end
                    else if (idx == mtg_pkg::STATE_WORDS)
                    begin
                        expected = {22'd0, pos_reg};
                    end
                end
                default:
                begin
                    if (idx < mtg_pkg::STATE_WORDS)
                    begin
                        if (!written[idx])
                        begin
                            written[idx]  = 1'b1;
                            written_count = written_count + 1;
                        end
                        store_words[idx] = val;
                    end
                    else if (idx == mtg_pkg::STATE_WORDS)
                    begin
                        pos_reg = val[9:0];
                    end
                end
            endcase
            pending_words.push_back(expected);
        endfunction

        function void check_beat(logic [31:0] got);
            mtg_pkg::word_t expected;
            if (pending_words.size() == 0)
            begin
                $error("result_word: expected none, actual %h", got);
                fail_count++;
            end
            else
            begin
                expected = pending_words.pop_front();
                if (got !== expected)
                begin
                    $error("result_word: expected %h, actual %h", expected, got);
                    fail_count++;
                end
            end
        endfunction
    endclass

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        start      = 1'b0;
    logic        busy;
    logic [1:0]  action     = mtg_pkg::ACT_GEN;
    logic [9:0]  word_index = '0;
    logic [31:0] data_value = '0;
    logic        done;
    logic [31:0] result_word;

    bit           idle_enabled = 1'b1;
    int unsigned  cycle_count  = 0;
    int unsigned  sent_count   = 0;
    mt_scoreboard sb;

    mersenne_twister_generator uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .word_index (word_index),
        .data_value (data_value),
        .done       (done),
        .result_word(result_word)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Issue one command, wait until busy is low again, then maybe idle a while
    task automatic send_command(input logic [1:0] act, input mtg_pkg::pos_t idx,
                                input mtg_pkg::word_t val);
        start      <= 1'b1;
        action     <= act;
        word_index <= idx;
        data_value <= val;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        sb.note_command(act, idx, val);
        sent_count = sent_count + 1;
        while (idle_enabled && $urandom_range(0, 99) < 27)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Save the position, draw a few words, restore it and draw the same number of words again
    task automatic replay_burst();
        mtg_pkg::pos_t  saved;
        mtg_pkg::word_t val;
        int unsigned    count;
        count = $urandom_range(1, 6);
        saved = sb.pos_reg;
        send_command(mtg_pkg::ACT_READ, mtg_pkg::STATE_WORDS, $urandom());
        repeat (count)
        begin
            send_command(mtg_pkg::ACT_GEN, mtg_pkg::pos_t'($urandom()), $urandom());
        end
        val      = $urandom();
        val[9:0] = saved;
        send_command(mtg_pkg::ACT_WRITE, mtg_pkg::STATE_WORDS, val);
        repeat (count)
        begin
            send_command(mtg_pkg::ACT_GEN, mtg_pkg::pos_t'($urandom()), $urandom());
        end
    endtask

    // Result monitor: every done beat is checked
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_beat(result_word);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("mersenne_twister_generator_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        int unsigned    pick;
        int unsigned    sub;
        logic [1:0]     act;
        mtg_pkg::pos_t  idx;
        mtg_pkg::word_t val;

        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: unseeded store access, bounds, seeding, position corners
        send_command(mtg_pkg::ACT_READ,   mtg_pkg::STATE_WORDS, 32'h0);
        send_command(mtg_pkg::ACT_READ,   10'h3FF, ALL_ONES);
        send_command(mtg_pkg::ACT_WRITE,  10'h3FF, ALL_ONES);
        send_command(mtg_pkg::ACT_WRITE,  10'd0, ALL_ONES);
        send_command(mtg_pkg::ACT_READ,   10'd0, 32'h0);
        send_command(mtg_pkg::ACT_WRITE,  mtg_pkg::LAST_WORD, 32'h0);
        send_command(mtg_pkg::ACT_READ,   mtg_pkg::LAST_WORD, 32'h0);
        send_command(mtg_pkg::ACT_GEN,    10'd0, 32'h0);          // self-seed with the default
        send_command(mtg_pkg::ACT_RESEED, 10'd0, ALL_ONES);       // all-ones picks the default
        send_command(mtg_pkg::ACT_GEN,    10'h3FF, ALL_ONES);
        send_command(mtg_pkg::ACT_RESEED, 10'd0, 32'h0);
        send_command(mtg_pkg::ACT_GEN,    10'd0, 32'h0);
        send_command(mtg_pkg::ACT_RESEED, 10'd0, 32'hFFFF_FFFE);
        send_command(mtg_pkg::ACT_WRITE,  mtg_pkg::STATE_WORDS, 32'hFFFF_FE6F); // position 623
        send_command(mtg_pkg::ACT_GEN,    10'd0, 32'h0);
        send_command(mtg_pkg::ACT_GEN,    10'd0, 32'h0);          // crosses into a refill
        send_command(mtg_pkg::ACT_WRITE,  mtg_pkg::STATE_WORDS, 32'h0000_0270); // position 624
        send_command(mtg_pkg::ACT_GEN,    10'd0, 32'h0);
        send_command(mtg_pkg::ACT_WRITE,  mtg_pkg::STATE_WORDS, 32'h0000_03FF); // refill only
        send_command(mtg_pkg::ACT_GEN,    10'd0, 32'h0);
        send_command(mtg_pkg::ACT_WRITE,  mtg_pkg::STATE_WORDS, 32'h0000_0271); // never seeded
        send_command(mtg_pkg::ACT_GEN,    10'd0, 32'h0);
        send_command(mtg_pkg::ACT_WRITE,  10'd5, 32'h0);
        send_command(mtg_pkg::ACT_WRITE,  mtg_pkg::STATE_WORDS, 32'h0000_0005);
        send_command(mtg_pkg::ACT_GEN,    10'd0, 32'h0);          // tempering of zero

        // Random mix; a long stretch in the middle runs with no idle cycles
        while (sent_count < ITEM_COUNT)
        begin
            idle_enabled = !(sent_count >= 150 && sent_count < 260);
            pick = $urandom_range(0, 99);
            sub  = $urandom_range(0, 19);
            idx  = mtg_pkg::pos_t'($urandom_range(0, NWORDS - 1));
            val  = $urandom();
            act  = mtg_pkg::ACT_GEN;
            if (pick < 50)
            begin
                idx = mtg_pkg::pos_t'($urandom());
            end
            else if (pick < 68)
            begin
                act = mtg_pkg::ACT_READ;
                if (sub == 0)
                begin
                    idx = mtg_pkg::STATE_WORDS;
                end
                else if (sub == 1)
                begin
                    idx = mtg_pkg::pos_t'($urandom_range(NWORDS + 1, 1023));
                end
            end
            else if (pick < 82)
            begin
                act = mtg_pkg::ACT_WRITE;
                if (sub == 0)
                begin
                    idx = mtg_pkg::pos_t'($urandom_range(NWORDS + 1, 1023));
                end
            end
            else if (pick < 88)
            begin
                // position writes, mostly near the end of the store
                act = mtg_pkg::ACT_WRITE;
                idx = mtg_pkg::STATE_WORDS;
                if (sub < 12)
                begin
                    val[9:0] = mtg_pkg::pos_t'($urandom_range(600, NWORDS - 1));
                end
                else if (sub < 17)
                begin
                    val[9:0] = mtg_pkg::pos_t'($urandom_range(0, NWORDS - 1));
                end
                else if (sub < 19)
                begin
                    val[9:0] = mtg_pkg::pos_t'($urandom());
                end
                else
                begin
                    val[9:0] = mtg_pkg::UNSEEDED;
                end
            end
            else if (pick < 93)
            begin
                act = mtg_pkg::ACT_RESEED;
                if (sub < 5)
                begin
                    val = ALL_ONES;
                end
            end
            else
            begin
                replay_burst();
                continue;
            end
            if (!sb.may_issue(act, idx))
            begin
                act = mtg_pkg::ACT_RESEED;
            end
            send_command(act, idx, val);
        end

        // Drain
        start <= 1'b0;
        while (sb.pending_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        if (sb.fail_count == 0 && sb.pending_words.size() == 0)
        begin
            $display("mersenne_twister_generator_tb: PASS");
        end
        else
        begin
            $display("mersenne_twister_generator_tb: FAIL");
        end
        $finish;
    end

endmodule
